// ===== hw/rtl/drt_pkg.sv =====
`timescale 1ns / 1ps
package drt_pkg;

  localparam int XW   = 12;
  localparam int WW   = 13;
  localparam int IW   = 14;
  localparam int LIMW = 6;
  localparam int CFGW = 13;
  localparam int THRW = 9;

  localparam logic [1:0] REQ_MARK  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_DRAIN = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [1:0] CFG_THRESH   = 2'd2;

  localparam logic [LIMW-1:0] MAX_OUT      = 6'd32;
  localparam logic [CFGW-1:0] SCREEN_MAX   = 13'd4096;
  localparam logic [CFGW-1:0] SCREEN_W_RST = 13'd1920;
  localparam logic [CFGW-1:0] SCREEN_H_RST = 13'd1080;
  localparam logic [THRW-1:0] THR_MAX      = 9'd256;
  localparam logic [THRW-1:0] THR_RST      = 9'd128;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [WW-1:0] w;
    logic [WW-1:0] h;
  } rect_t;

  localparam int RECTW = $bits(rect_t);

  typedef enum logic [2:0] {
    RD_ZERO, RD_I, RD_J, RD_J1, RD_K, RD_K1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_N, WR_I, WR_K, WR_ZERO
  } wr_sel_t;

  typedef struct packed {
    logic       latch;
    logic       clip;
    logic       mark_mul;
    logic       mark_add;
    logic       clear;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       col_wr;
    logic       i_clr;
    logic       i_inc;
    logic       j_set;
    logic       j_inc;
    logic       k_one;
    logic       k_clr;
    logic       k_from_j;
    logic       k_inc;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       a_ld;
    logic       a_bound;
    logic       st_set;
    logic [1:0] st_val;
    logic       elim;
    logic       out_load;
    logic       out_rect;
  } drt_cmd_t;

  typedef struct packed {
    logic       layer_ok;
    logic [1:0] req;
    logic       clip_empty;
    logic       full;
    logic       over;
    logic       i_end;
    logic       j_more;
    logic       k_more;
    logic       k1_more;
    logic       hit;
    logic       e_zero;
    logic       e_last;
    logic       out_busy;
  } drt_sts_t;

endpackage

// ===== hw/rtl/drt_ram.sv =====
`timescale 1ns / 1ps
module drt_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/drt_dpath.sv =====
`timescale 1ns / 1ps
module drt_dpath import drt_pkg::*; #(
  parameter int MAX_RECTS = 32,
  parameter int LAYERS    = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFGW-1:0]        cfg_data,
  input  logic [1:0]             in_req_type,
  input  logic [1:0]             in_layer,
  input  logic signed [IW-1:0]   in_rect_x,
  input  logic signed [IW-1:0]   in_rect_y,
  input  logic signed [IW-1:0]   in_rect_width,
  input  logic signed [IW-1:0]   in_rect_height,
  input  logic [LIMW-1:0]        in_readout_limit,
  input  drt_cmd_t               cmd,
  output drt_sts_t               sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [XW-1:0]          out_x,
  output logic [XW-1:0]          out_y,
  output logic [WW-1:0]          out_width,
  output logic [WW-1:0]          out_height,
  output logic                   out_rect_valid,
  output logic                   out_last,
  output logic [1:0]             out_status
);

  localparam int SW    = $clog2(MAX_RECTS);
  localparam int CW    = $clog2(MAX_RECTS + 1);
  localparam int CW1   = CW + 1;
  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int AW    = LW + SW;
  localparam int DEPTH = 2 ** AW;
  localparam int EW    = (CW > LIMW) ? CW : LIMW;

  logic [CFGW-1:0] sw_r, sh_r;
  logic [THRW-1:0] thr_r;

  logic [1:0]             req_r, layer_r;
  logic signed [IW-1:0]   rx_r, ry_r, rw_r, rh_r;
  logic [LIMW-1:0]        lim_r;

  rect_t                  clip_r, a_r, rd_data;
  logic                   clip_empty_r;
  logic [CW-1:0]          cnt_r [LAYERS];
  logic [31:0]            area_r [LAYERS];
  logic [CW-1:0]          i_r, j_r, k_r, e_r;
  logic [2*WW-1:0]        wh_r, scr_r;
  logic [2*WW+THRW-1:0]   thrp_r;
  logic [1:0]             st_r;

  logic [LW-1:0]          lidx;
  logic [CW-1:0]          cur_cnt;
  logic [31:0]            cur_area;
  logic [CFGW-1:0]        sw_eff, sh_eff;
  logic [THRW-1:0]        thr_eff;

  assign lidx     = LW'(layer_r);
  assign cur_cnt  = cnt_r[lidx];
  assign cur_area = area_r[lidx];
  assign sw_eff   = (sw_r == '0) ? CFGW'(1) : ((sw_r > SCREEN_MAX) ? SCREEN_MAX : sw_r);
  assign sh_eff   = (sh_r == '0) ? CFGW'(1) : ((sh_r > SCREEN_MAX) ? SCREEN_MAX : sh_r);
  assign thr_eff  = (thr_r > THR_MAX) ? THR_MAX : thr_r;

  // clipping
  logic signed [15:0] cx, cy, cw, ch, sws, shs;
  logic               c_empty;
  always_comb begin
    cx  = 16'(rx_r);
    cy  = 16'(ry_r);
    cw  = 16'(rw_r);
    ch  = 16'(rh_r);
    sws = signed'({3'b000, sw_eff});
    shs = signed'({3'b000, sh_eff});
    if (cx < 0) begin
      cw = cw + cx;
      cx = '0;
    end
    if (cy < 0) begin
      ch = ch + cy;
      cy = '0;
    end
    if (cx + cw > sws) begin
      cw = sws - cx;
    end
    if (cy + ch > shs) begin
      ch = shs - cy;
    end
    c_empty = (cw <= 0) || (ch <= 0);
  end

  // overlap and bounding box of a_r with the read entry
  logic [XW+1:0] ax2, ay2, bx2, by2, x2, y2;
  logic [XW-1:0] x1, y1;
  logic          hit;
  rect_t         bnd;
  always_comb begin
    ax2 = 14'(a_r.x) + 14'(a_r.w);
    ay2 = 14'(a_r.y) + 14'(a_r.h);
    bx2 = 14'(rd_data.x) + 14'(rd_data.w);
    by2 = 14'(rd_data.y) + 14'(rd_data.h);
    hit = !((ax2 <= 14'(rd_data.x)) || (bx2 <= 14'(a_r.x)) ||
            (ay2 <= 14'(rd_data.y)) || (by2 <= 14'(a_r.y)));
    x1  = (a_r.x < rd_data.x) ? a_r.x : rd_data.x;
    y1  = (a_r.y < rd_data.y) ? a_r.y : rd_data.y;
    x2  = (ax2 > bx2) ? ax2 : bx2;
    y2  = (ay2 > by2) ? ay2 : by2;
    bnd.x = x1;
    bnd.y = y1;
    bnd.w = WW'(x2 - 14'(x1));
    bnd.h = WW'(y2 - 14'(y1));
  end

  // store addressing
  logic [CW-1:0] j_nx, k_nx;
  logic [SW-1:0] rd_slot, wr_slot;
  rect_t         wr_data;
  assign j_nx = j_r + CW'(1);
  assign k_nx = k_r + CW'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_I:    rd_slot = i_r[SW-1:0];
      RD_J:    rd_slot = j_r[SW-1:0];
      RD_J1:   rd_slot = j_nx[SW-1:0];
      RD_K:    rd_slot = k_r[SW-1:0];
      RD_K1:   rd_slot = k_nx[SW-1:0];
      default: rd_slot = '0;
    endcase
    case (cmd.wr_sel)
      WR_N: begin
        wr_slot = cur_cnt[SW-1:0];
        wr_data = clip_r;
      end
      WR_I: begin
        wr_slot = i_r[SW-1:0];
        wr_data = a_r;
      end
      WR_K: begin
        wr_slot = k_r[SW-1:0];
        wr_data = rd_data;
      end
      default: begin
        wr_slot = '0;
        wr_data = a_r;
      end
    endcase
  end

  drt_ram #(
    .WIDTH (RECTW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr ({lidx, wr_slot}),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr ({lidx, rd_slot}),
    .rd_data (rd_data)
  );

  // drain limit
  logic [LIMW-1:0] lim_c;
  logic [EW-1:0]   e_min;
  assign lim_c = (lim_r > MAX_OUT) ? MAX_OUT : lim_r;
  assign e_min = (EW'(lim_c) < EW'(cur_cnt)) ? EW'(lim_c) : EW'(cur_cnt);

  logic [32:0] area_sum;
  assign area_sum = {1'b0, cur_area} + 33'(wh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= SCREEN_W_RST;
      sh_r  <= SCREEN_H_RST;
      thr_r <= THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_W: sw_r  <= cfg_data;
        CFG_SCREEN_H: sh_r  <= cfg_data;
        CFG_THRESH:   thr_r <= cfg_data[THRW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < LAYERS; l++) begin
        cnt_r[l]  <= '0;
        area_r[l] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        cnt_r[lidx]  <= '0;
        area_r[lidx] <= '0;
      end
      if (cmd.cnt_inc) begin
        cnt_r[lidx] <= cur_cnt + CW'(1);
      end
      if (cmd.cnt_dec) begin
        cnt_r[lidx] <= cur_cnt - CW'(1);
      end
      if (cmd.mark_add) begin
        area_r[lidx] <= area_sum[32] ? '1 : area_sum[31:0];
      end
      if (cmd.col_wr) begin
        cnt_r[lidx]  <= CW'(1);
        area_r[lidx] <= 32'(a_r.w) * 32'(a_r.h);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r   <= in_req_type;
      layer_r <= in_layer;
      rx_r    <= in_rect_x;
      ry_r    <= in_rect_y;
      rw_r    <= in_rect_width;
      rh_r    <= in_rect_height;
      lim_r   <= in_readout_limit;
    end
    if (cmd.clip) begin
      clip_r.x     <= cx[XW-1:0];
      clip_r.y     <= cy[XW-1:0];
      clip_r.w     <= cw[WW-1:0];
      clip_r.h     <= ch[WW-1:0];
      clip_empty_r <= c_empty;
    end
    if (cmd.mark_mul) begin
      wh_r  <= clip_r.w * clip_r.h;
      scr_r <= sw_eff * sh_eff;
    end
    if (cmd.mark_add) begin
      thrp_r <= scr_r * thr_eff;
    end
    if (cmd.a_ld) begin
      a_r <= rd_data;
    end
    if (cmd.a_bound) begin
      a_r <= bnd;
    end
    if (cmd.i_clr) begin
      i_r <= '0;
    end
    if (cmd.i_inc) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.j_set) begin
      j_r <= i_r + CW'(1);
    end
    if (cmd.j_inc) begin
      j_r <= j_nx;
    end
    if (cmd.k_one) begin
      k_r <= CW'(1);
    end
    if (cmd.k_clr) begin
      k_r <= '0;
    end
    if (cmd.k_from_j) begin
      k_r <= j_r;
    end
    if (cmd.k_inc) begin
      k_r <= k_nx;
    end
    if (cmd.elim) begin
      e_r <= CW'(e_min);
    end
    if (cmd.st_set) begin
      st_r <= cmd.st_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_rect) begin
        out_x          <= rd_data.x;
        out_y          <= rd_data.y;
        out_width      <= rd_data.w;
        out_height     <= rd_data.h;
        out_rect_valid <= 1'b1;
        out_last       <= sts.e_last;
        out_status     <= ST_OK;
      end else begin
        out_x          <= '0;
        out_y          <= '0;
        out_width      <= '0;
        out_height     <= '0;
        out_rect_valid <= 1'b0;
        out_last       <= 1'b1;
        out_status     <= st_r;
      end
    end
  end

  always_comb begin
    sts.layer_ok   = int'(layer_r) < LAYERS;
    sts.req        = req_r;
    sts.clip_empty = clip_empty_r;
    sts.full       = cur_cnt >= CW'(MAX_RECTS);
    sts.over       = ({cur_area, 8'b0} > 40'(thrp_r)) && (cur_cnt > CW'(1));
    sts.i_end      = (CW1'(i_r) + CW1'(1)) >= CW1'(cur_cnt);
    sts.j_more     = (CW1'(j_r) + CW1'(1)) < CW1'(cur_cnt);
    sts.k_more     = k_r < cur_cnt;
    sts.k1_more    = (CW1'(k_r) + CW1'(1)) < CW1'(cur_cnt);
    sts.hit        = hit;
    sts.e_zero     = e_r == '0;
    sts.e_last     = (CW1'(k_r) + CW1'(1)) == CW1'(e_r);
    sts.out_busy   = out_valid && !out_ready;
  end

endmodule

// ===== hw/rtl/drt_ctrl.sv =====
`timescale 1ns / 1ps
module drt_ctrl import drt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  drt_sts_t sts,
  output drt_cmd_t cmd
);

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_DISPATCH = 20'h00002,
    S_MARK_CHK = 20'h00004,
    S_MARK_ADD = 20'h00008,
    S_MARK_CMP = 20'h00010,
    S_COL_RD0  = 20'h00020,
    S_COL_LD0  = 20'h00040,
    S_COL_ACC  = 20'h00080,
    S_COL_WR   = 20'h00100,
    S_M_RDI    = 20'h00200,
    S_M_LDI    = 20'h00400,
    S_M_CMP    = 20'h00800,
    S_M_WRI    = 20'h01000,
    S_M_SH_RD  = 20'h02000,
    S_M_SH_WR  = 20'h04000,
    S_E_INIT   = 20'h08000,
    S_E_CHK    = 20'h10000,
    S_E_RD     = 20'h20000,
    S_E_OUT    = 20'h40000,
    S_RESP     = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.st_set = 1'b1;
        cmd.st_val = ST_OK;
        if (!sts.layer_ok) begin
          state_nxt = S_RESP;
        end else begin
          unique case (sts.req)
            REQ_MARK: begin
              cmd.clip  = 1'b1;
              state_nxt = S_MARK_CHK;
            end
            REQ_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_RESP;
            end
            REQ_DRAIN: begin
              cmd.i_clr = 1'b1;
              state_nxt = S_M_RDI;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_MARK_CHK: begin
        if (sts.clip_empty) begin
          cmd.st_set = 1'b1;
          cmd.st_val = ST_EMPTY;
          state_nxt  = S_RESP;
        end else if (sts.full) begin
          cmd.st_set = 1'b1;
          cmd.st_val = ST_FULL;
          state_nxt  = S_RESP;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_N;
          cmd.cnt_inc  = 1'b1;
          cmd.mark_mul = 1'b1;
          state_nxt    = S_MARK_ADD;
        end
      end
      S_MARK_ADD: begin
        cmd.mark_add = 1'b1;
        state_nxt    = S_MARK_CMP;
      end
      S_MARK_CMP: begin
        state_nxt = sts.over ? S_COL_RD0 : S_RESP;
      end
      S_COL_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_ZERO;
        cmd.k_one  = 1'b1;
        state_nxt  = S_COL_LD0;
      end
      S_COL_LD0: begin
        cmd.a_ld   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_K;
        cmd.k_inc  = 1'b1;
        state_nxt  = S_COL_ACC;
      end
      S_COL_ACC: begin
        cmd.a_bound = 1'b1;
        if (sts.k_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_K;
          cmd.k_inc  = 1'b1;
        end else begin
          state_nxt = S_COL_WR;
        end
      end
      S_COL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ZERO;
        cmd.col_wr = 1'b1;
        state_nxt  = S_RESP;
      end
      S_M_RDI: begin
        if (sts.i_end) begin
          state_nxt = S_E_INIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_I;
          cmd.j_set  = 1'b1;
          state_nxt  = S_M_LDI;
        end
      end
      S_M_LDI: begin
        cmd.a_ld   = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_J;
        state_nxt  = S_M_CMP;
      end
      S_M_CMP: begin
        if (sts.hit) begin
          cmd.a_bound  = 1'b1;
          cmd.k_from_j = 1'b1;
          state_nxt    = S_M_WRI;
        end else if (sts.j_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_J1;
          cmd.j_inc  = 1'b1;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_M_RDI;
        end
      end
      S_M_WRI: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_I;
        state_nxt  = S_M_SH_RD;
      end
      S_M_SH_RD: begin
        if (sts.k1_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_K1;
          state_nxt  = S_M_SH_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          cmd.i_clr   = 1'b1;
          state_nxt   = S_M_RDI;
        end
      end
      S_M_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_K;
        cmd.k_inc  = 1'b1;
        state_nxt  = S_M_SH_RD;
      end
      S_E_INIT: begin
        cmd.elim  = 1'b1;
        state_nxt = S_E_CHK;
      end
      S_E_CHK: begin
        if (sts.e_zero) begin
          state_nxt = S_RESP;
        end else begin
          cmd.k_clr = 1'b1;
          state_nxt = S_E_RD;
        end
      end
      S_E_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_K;
        state_nxt  = S_E_OUT;
      end
      S_E_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_rect = 1'b1;
          if (sts.e_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = S_E_RD;
          end
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/dirty_rect_tracker.sv =====
`timescale 1ns / 1ps
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_ready  | request: type, layer, rectangle, limit
// out_     | output    | out_valid/out_ready  | rectangle, rect_valid, last, status
// cfg_     | input     | cfg_we               | cfg_index, cfg_data
// One request at a time; in_ready is high only when the controller is idle.
// Mark: when the layer collapses, each entry is read from the store once and bounded into entry 0.
// Drain: merge pass walks pairs through the single-read store, restarting after each
// merge and shifting the later entries down by one; then the stored rectangles are
// emitted, up to the readout limit.
// Reset (rst_n, synchronous) empties every layer at once; no clearing pass.
// A stalled output holds the controller; one result waits in the output register.
module dirty_rect_tracker import drt_pkg::*; #(
  parameter int MAX_RECTS = 32,
  parameter int LAYERS    = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFGW-1:0]      cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [1:0]           in_layer,
  input  logic signed [IW-1:0] in_rect_x,
  input  logic signed [IW-1:0] in_rect_y,
  input  logic signed [IW-1:0] in_rect_width,
  input  logic signed [IW-1:0] in_rect_height,
  input  logic [LIMW-1:0]      in_readout_limit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [XW-1:0]        out_x,
  output logic [XW-1:0]        out_y,
  output logic [WW-1:0]        out_width,
  output logic [WW-1:0]        out_height,
  output logic                 out_rect_valid,
  output logic                 out_last,
  output logic [1:0]           out_status
);

  drt_cmd_t cmd;
  drt_sts_t sts;

  drt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  drt_dpath #(
    .MAX_RECTS (MAX_RECTS),
    .LAYERS    (LAYERS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_layer         (in_layer),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_readout_limit (in_readout_limit),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_width        (out_width),
    .out_height       (out_height),
    .out_rect_valid   (out_rect_valid),
    .out_last         (out_last),
    .out_status       (out_status)
  );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import drt_pkg::*;

  localparam int NRECT   = 32;
  localparam int NLAYER  = 4;
  localparam int N_RAND  = 460;
  localparam int LIMIT_CYCLES = 5000000;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [XW-1:0] y;
    logic [WW-1:0] w;
    logic [WW-1:0] h;
    logic          rv;
    logic          last;
    logic [1:0]    st;
  } damage_out_t;

  typedef struct {
    logic [1:0]      req;
    logic [1:0]      layer;
    logic [IW-1:0]   x, y, w, h;
    logic [LIMW-1:0] lim;
    bit              has_exp;
    logic [1:0]      exp_st;
  } req_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_SCREEN_W;
  logic [CFGW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_req_type = REQ_MARK;
  logic [1:0] in_layer = '0;
  logic signed [IW-1:0] in_rect_x = '0, in_rect_y = '0, in_rect_width = '0, in_rect_height = '0;
  logic [LIMW-1:0] in_readout_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [XW-1:0] out_x, out_y;
  logic [WW-1:0] out_width, out_height;
  logic out_rect_valid, out_last;
  logic [1:0] out_status;

  dirty_rect_tracker u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  int unsigned scr_w, scr_h, thresh;
  int unsigned pr_x[NLAYER][NRECT], pr_y[NLAYER][NRECT];
  int unsigned pr_w[NLAYER][NRECT], pr_h[NLAYER][NRECT];
  int unsigned pr_cnt[NLAYER];
  longint unsigned pr_area[NLAYER];

  damage_out_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_rects = 0;
  int n_collapse = 0;
  int n_full = 0;
  int n_reqs = 0;
  longint cycle = 0;

  task automatic report(input string what, input damage_out_t got, input damage_out_t exp);
    errors++;
    $display("MISMATCH %s at cycle %0d: got %h exp %h", what, cycle, got, exp);
  endtask

  function automatic int unsigned clampd(input int unsigned v);
    if (v < 1) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic void bound_pair(input int l, input int a, input int b);
    int unsigned x1, y1, x2, y2;
    x1 = pr_x[l][a] < pr_x[l][b] ? pr_x[l][a] : pr_x[l][b];
    y1 = pr_y[l][a] < pr_y[l][b] ? pr_y[l][a] : pr_y[l][b];
    x2 = pr_x[l][a] + pr_w[l][a];
    if (pr_x[l][b] + pr_w[l][b] > x2) x2 = pr_x[l][b] + pr_w[l][b];
    y2 = pr_y[l][a] + pr_h[l][a];
    if (pr_y[l][b] + pr_h[l][b] > y2) y2 = pr_y[l][b] + pr_h[l][b];
    pr_x[l][a] = x1; pr_y[l][a] = y1; pr_w[l][a] = x2 - x1; pr_h[l][a] = y2 - y1;
  endfunction

  function automatic bit hits(input int l, input int a, input int b);
    return !(pr_x[l][a] + pr_w[l][a] <= pr_x[l][b] || pr_x[l][b] + pr_w[l][b] <= pr_x[l][a] ||
             pr_y[l][a] + pr_h[l][a] <= pr_y[l][b] || pr_y[l][b] + pr_h[l][b] <= pr_y[l][a]);
  endfunction

  function automatic damage_out_t mk(input int unsigned x, y, w, h, input bit rv, lst,
                                     input logic [1:0] st);
    damage_out_t r;
    r.x = XW'(x); r.y = XW'(y); r.w = WW'(w); r.h = WW'(h);
    r.rv = rv; r.last = lst; r.st = st;
    return r;
  endfunction

  function automatic logic [1:0] mark_damage(input int l, input logic signed [IW-1:0] ix, iy,
                                             iw, ih);
    int x, y, w, h, sw, sh;
    int unsigned n;
    longint unsigned tot;
    x = ix; y = iy; w = iw; h = ih;
    sw = clampd(scr_w); sh = clampd(scr_h);
    if (x < 0) begin w += x; x = 0; end
    if (y < 0) begin h += y; y = 0; end
    if (x + w > sw) w = sw - x;
    if (y + h > sh) h = sh - y;
    if (w <= 0 || h <= 0) return ST_EMPTY;
    n = pr_cnt[l];
    if (n >= NRECT) begin n_full++; return ST_FULL; end
    pr_x[l][n] = x; pr_y[l][n] = y; pr_w[l][n] = w; pr_h[l][n] = h;
    pr_cnt[l] = n + 1;
    tot = pr_area[l] + longint'(w) * longint'(h);
    if (tot > 64'hFFFF_FFFF) tot = 64'hFFFF_FFFF;
    pr_area[l] = tot;
    if (tot * 256 > longint'(sw) * longint'(sh) * (thresh > 256 ? 256 : thresh) &&
        pr_cnt[l] > 1) begin
      for (int i = 1; i < pr_cnt[l]; i++) bound_pair(l, 0, i);
      pr_cnt[l] = 1;
      pr_area[l] = longint'(pr_w[l][0]) * pr_h[l][0];
      n_collapse++;
    end
    return ST_OK;
  endfunction

  task automatic predict_request(input req_row_t r);
    int l, lim, n;
    bit changed;
    l = r.layer;
    n_reqs++;
    if (r.req == REQ_MARK) begin
      expected_q.push_back(mk(0, 0, 0, 0, 0, 1, mark_damage(l, r.x, r.y, r.w, r.h)));
    end else if (r.req == REQ_CLEAR) begin
      pr_cnt[l] = 0; pr_area[l] = 0;
      expected_q.push_back(mk(0, 0, 0, 0, 0, 1, ST_OK));
    end else if (r.req == REQ_DRAIN) begin
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int i = 0; i < pr_cnt[l] && !changed; i++)
          for (int j = i + 1; j < pr_cnt[l] && !changed; j++)
            if (hits(l, i, j)) begin
              bound_pair(l, i, j);
              for (int k = j; k < pr_cnt[l] - 1; k++) begin
                pr_x[l][k] = pr_x[l][k+1]; pr_y[l][k] = pr_y[l][k+1];
                pr_w[l][k] = pr_w[l][k+1]; pr_h[l][k] = pr_h[l][k+1];
              end
              pr_cnt[l]--;
              changed = 1;
            end
      end
      lim = r.lim > MAX_OUT ? MAX_OUT : r.lim;
      n = pr_cnt[l] < lim ? pr_cnt[l] : lim;
      if (n == 0) expected_q.push_back(mk(0, 0, 0, 0, 0, 1, ST_OK));
      for (int k = 0; k < n; k++)
        expected_q.push_back(mk(pr_x[l][k], pr_y[l][k], pr_w[l][k], pr_h[l][k], 1,
                                k == n - 1, ST_OK));
    end else begin
      expected_q.push_back(mk(0, 0, 0, 0, 0, 1, ST_OK));
    end
  endtask

  // result side
  always @(posedge clk) begin
    damage_out_t got, exp;
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycle);
      $display("tb_top failed");
      $finish;
    end
    if (out_valid && out_ready) begin
      got = mk(out_x, out_y, out_width, out_height, out_rect_valid, out_last, out_status);
      n_results++;
      if (out_rect_valid) n_rects++;
      if (expected_q.size() == 0) begin
        report("unexpected result", got, got);
      end else begin
        exp = expected_q.pop_front();
        if (got.x !== exp.x) report("out_x", got, exp);
        if (got.y !== exp.y) report("out_y", got, exp);
        if (got.w !== exp.w) report("out_width", got, exp);
        if (got.h !== exp.h) report("out_height", got, exp);
        if (got.rv !== exp.rv) report("out_rect_valid", got, exp);
        if (got.last !== exp.last) report("out_last", got, exp);
        if (got.st !== exp.st) report("out_status", got, exp);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      stall_left = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) stall_left = 0;
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send(input req_row_t r);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_req_type <= r.req; in_layer <= r.layer;
    in_rect_x <= r.x; in_rect_y <= r.y; in_rect_width <= r.w; in_rect_height <= r.h;
    in_readout_limit <= r.lim;
    predict_request(r);
    if (r.has_exp && expected_q[$].st !== r.exp_st)
      report("table status", expected_q[$], mk(0, 0, 0, 0, 0, 1, r.exp_st));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= CFGW'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_W: scr_w = v;
      CFG_SCREEN_H: scr_h = v;
      default:      thresh = v;
    endcase
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic req_row_t row(input logic [1:0] rq, input int l, x, y, w, h, lim,
                                   input bit he, input logic [1:0] es);
    req_row_t r;
    r.req = rq; r.layer = 2'(l); r.x = IW'(x); r.y = IW'(y); r.w = IW'(w); r.h = IW'(h);
    r.lim = LIMW'(lim);
    r.has_exp = he; r.exp_st = es;
    return r;
  endfunction

  function automatic req_row_t rand_row(input int wmax);
    req_row_t r;
    int p;
    p = $urandom_range(0, 99);
    r.layer = 2'($urandom_range(0, 3));
    r.has_exp = 0; r.exp_st = ST_OK;
    r.lim = LIMW'($urandom_range(0, 9) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 12));
    if (p < 70) r.req = REQ_MARK;
    else if (p < 78) r.req = REQ_CLEAR;
    else if (p < 96) r.req = REQ_DRAIN;
    else r.req = 2'd3;
    if ($urandom_range(0, 9) == 0) begin
      r.x = IW'($urandom); r.y = IW'($urandom); r.w = IW'($urandom); r.h = IW'($urandom);
    end else begin
      r.x = IW'($signed($urandom_range(0, wmax + 40)) - 20);
      r.y = IW'($signed($urandom_range(0, wmax + 40)) - 20);
      r.w = IW'($urandom_range(0, wmax / 3 + 2));
      r.h = IW'($urandom_range(0, wmax / 3 + 2));
    end
    return r;
  endfunction

  req_row_t dir_tbl[$];

  initial begin
    scr_w = SCREEN_W_RST; scr_h = SCREEN_H_RST; thresh = THR_RST;
    foreach (pr_cnt[l]) begin pr_cnt[l] = 0; pr_area[l] = 0; end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_tbl.push_back(row(REQ_DRAIN, 0, 0, 0, 0, 0, 5, 0, ST_OK));
    dir_tbl.push_back(row(REQ_MARK, 0, -8192, -8192, 8191, 8191, 0, 1, ST_EMPTY));
    dir_tbl.push_back(row(REQ_MARK, 0, 8191, 8191, 10, 10, 0, 1, ST_EMPTY));
    dir_tbl.push_back(row(REQ_MARK, 0, 0, 0, 0, 5, 0, 1, ST_EMPTY));
    dir_tbl.push_back(row(REQ_MARK, 0, 0, 0, -8192, -8192, 0, 1, ST_EMPTY));
    dir_tbl.push_back(row(REQ_MARK, 0, -5, -7, 20, 20, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_MARK, 0, 1900, 1070, 100, 100, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_MARK, 0, 10, 10, 20, 20, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_MARK, 0, 100, 100, 5, 5, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_DRAIN, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    dir_tbl.push_back(row(REQ_DRAIN, 0, 0, 0, 0, 0, 63, 0, ST_OK));
    dir_tbl.push_back(row(2'd3, 1, 0, 0, 0, 0, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_MARK, 3, 0, 0, 1920, 1080, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_MARK, 3, 0, 0, 8, 8, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_DRAIN, 3, 0, 0, 0, 0, 32, 0, ST_OK));
    dir_tbl.push_back(row(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 1, ST_OK));
    dir_tbl.push_back(row(REQ_DRAIN, 0, 0, 0, 0, 0, 4, 0, ST_OK));
    foreach (dir_tbl[i]) send(dir_tbl[i]);
    for (int i = 0; i < 34; i++)
      send(row(REQ_MARK, 2, 40 * i, 0, 3, 3, 0, 0, ST_OK));
    send(row(REQ_DRAIN, 2, 0, 0, 0, 0, 33, 0, ST_OK));
    drain_idle();

    for (int ph = 0; ph < 5; ph++) begin
      int wmax;
      case (ph)
        0: begin write_reg(CFG_SCREEN_W, 0); write_reg(CFG_SCREEN_H, 0);
                 write_reg(CFG_THRESH, 0); end
        1: begin write_reg(CFG_SCREEN_W, 8191); write_reg(CFG_SCREEN_H, 4096);
                 write_reg(CFG_THRESH, 511); end
        2: begin write_reg(CFG_SCREEN_W, 64); write_reg(CFG_SCREEN_H, 48);
                 write_reg(CFG_THRESH, 256); end
        3: begin write_reg(CFG_SCREEN_W, 200); write_reg(CFG_SCREEN_H, 150);
                 write_reg(CFG_THRESH, 40); end
        default: begin write_reg(CFG_SCREEN_W, 1); write_reg(CFG_SCREEN_H, 4096);
                 write_reg(CFG_THRESH, 128); end
      endcase
      wmax = clampd(scr_w) > clampd(scr_h) ? clampd(scr_w) : clampd(scr_h);
      if (wmax > 600) wmax = 600;
      for (int i = 0; i < N_RAND / 5; i++) begin
        send(rand_row(wmax));
        if (ph == 2 && i == 40) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
      end
      drain_idle();
    end

    $display("covered %0d requests, %0d results (%0d rectangles), %0d collapses, %0d full drops",
             n_reqs, n_results, n_rects, n_collapse, n_full);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_q.size());
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/drt_pkg.sv
hw/rtl/drt_ram.sv
hw/rtl/drt_dpath.sv
hw/rtl/drt_ctrl.sv
hw/rtl/dirty_rect_tracker.sv
sim/tb_top.sv
